// ===== src/grq_pkg.sv =====
// Shared constants, codes and interface types for the graph reachability query block.
`timescale 1ns / 1ps

package grq_pkg;

    // Graph size and field widths.
    localparam int MAX_VERTICES = 64;
    localparam int IDX_W        = $clog2(MAX_VERTICES);
    localparam int VTX_W        = 7;
    localparam int ACT_W        = 2;

    // Action codes carried by an input item.
    localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd0;
    localparam logic [ACT_W-1:0] ACT_ADD   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_QUERY = 2'd2;

    // Which row address the datapath reads.
    typedef enum logic [1:0] {
        RD_ROW_A,
        RD_ROW_B,
        RD_ROW_PEND
    } t_rd_sel;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load;
        logic    clear_edges;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    wr_en;
        logic    wr_row_b;
        logic    q_init;
        logic    merge;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic             ops_ok;
        logic             pend_empty;
    } t_dp_status;

endpackage

// ===== src/grq_datapath.sv =====
// Datapath: adjacency row memory, visited and pending sets, operand and result registers.
`timescale 1ns / 1ps

module grq_datapath
    import grq_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_dp_cmd          i_cmd,
    output t_dp_status       o_status_bus,
    input  logic [ACT_W-1:0] i_action,
    input  logic [VTX_W-1:0] i_first_vertex,
    input  logic [VTX_W-1:0] i_second_vertex,
    input  logic             i_cfg_we,
    input  logic [VTX_W-1:0] i_cfg_data,
    output logic             o_path_found,
    output logic             o_status
);

    // Adjacency memory with one valid bit per row.
    logic [MAX_VERTICES-1:0] r_adj_mem [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] r_row_valid;

    logic [VTX_W-1:0]        r_vertex_count;
    logic [ACT_W-1:0]        r_action;
    logic [VTX_W-1:0]        r_a;
    logic [VTX_W-1:0]        r_b;
    logic                    r_ops_ok;
    logic [MAX_VERTICES-1:0] r_active_mask;
    logic [MAX_VERTICES-1:0] r_rd_data;
    logic                    r_rd_valid;
    logic [MAX_VERTICES-1:0] r_visited;
    logic [MAX_VERTICES-1:0] r_pending;
    logic                    r_found;
    logic                    r_status;

    logic [VTX_W-1:0]        n_eff;
    logic                    n_a_ok;
    logic                    n_b_ok;
    logic [MAX_VERTICES-1:0] n_mask;
    logic [IDX_W-1:0]        idx_a;
    logic [IDX_W-1:0]        idx_b;
    logic [MAX_VERTICES-1:0] pend_low;
    logic [IDX_W-1:0]        pend_idx;
    logic [IDX_W-1:0]        rd_addr;
    logic [IDX_W-1:0]        wr_addr;
    logic [IDX_W-1:0]        wr_bit;
    logic [MAX_VERTICES-1:0] row_now;
    logic [MAX_VERTICES-1:0] new_verts;

    // Effective vertex count, range checks and active-vertex mask for a new item.
    always_comb begin
        n_eff = (r_vertex_count > VTX_W'(MAX_VERTICES)) ? VTX_W'(MAX_VERTICES)
                                                        : r_vertex_count;
        n_a_ok = (i_first_vertex != '0) && (i_first_vertex <= n_eff);
        n_b_ok = (i_second_vertex != '0) && (i_second_vertex <= n_eff);
        for (int i = 0; i < MAX_VERTICES; i++) begin
            n_mask[i] = (VTX_W'(i) < n_eff);
        end
    end

    assign idx_a = IDX_W'(r_a - VTX_W'(1));
    assign idx_b = IDX_W'(r_b - VTX_W'(1));

    // Lowest pending vertex: isolate the lowest set bit, then encode it.
    always_comb begin
        pend_low = r_pending & (~r_pending + MAX_VERTICES'(1));
        pend_idx = '0;
        for (int i = 0; i < MAX_VERTICES; i++) begin
            if (pend_low[i]) begin
                pend_idx = pend_idx | IDX_W'(i);
            end
        end
    end

    // Read and write address selection.
    always_comb begin
        unique case (i_cmd.rd_sel)
            RD_ROW_A:    rd_addr = idx_a;
            RD_ROW_B:    rd_addr = idx_b;
            RD_ROW_PEND: rd_addr = pend_idx;
            default:     rd_addr = pend_idx;
        endcase
        wr_addr = i_cmd.wr_row_b ? idx_b : idx_a;
        wr_bit  = i_cmd.wr_row_b ? idx_a : idx_b;
    end

    // A row that was never written since the last clear reads as empty.
    assign row_now   = r_rd_valid ? r_rd_data : '0;
    assign new_verts = row_now & ~r_visited & r_active_mask;

    // Memory port: one registered read and one write per cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_data <= r_adj_mem[rd_addr];
        end
        if (i_cmd.wr_en) begin
            r_adj_mem[wr_addr] <= row_now | (MAX_VERTICES'(1) << wr_bit);
        end
    end

    // Row valid bits, configuration and search state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid    <= '0;
            r_rd_valid     <= 1'b0;
            r_vertex_count <= VTX_W'(MAX_VERTICES);
            r_visited      <= '0;
            r_pending      <= '0;
            r_found        <= 1'b0;
            r_status       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_vertex_count <= i_cfg_data;
            end
            if (i_cmd.rd_en) begin
                r_rd_valid <= r_row_valid[rd_addr];
            end
            if (i_cmd.clear_edges) begin
                r_row_valid <= '0;
                r_visited   <= '0;
            end else if (i_cmd.wr_en) begin
                r_row_valid[wr_addr] <= 1'b1;
            end
            if (i_cmd.load) begin
                r_found  <= 1'b0;
                r_status <= !(n_a_ok && n_b_ok);
            end
            if (i_cmd.q_init) begin
                r_visited <= MAX_VERTICES'(1) << idx_a;
                r_pending <= MAX_VERTICES'(1) << idx_a;
            end else if (i_cmd.rd_en && i_cmd.rd_sel == RD_ROW_PEND) begin
                r_pending <= r_pending & ~pend_low;
            end else if (i_cmd.merge) begin
                r_visited <= r_visited | new_verts;
                r_pending <= r_pending | new_verts;
                if (row_now[idx_b]) begin
                    r_found <= 1'b1;
                end
            end
        end
    end

    // Operand registers captured when an item is accepted.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action      <= i_action;
            r_a           <= i_first_vertex;
            r_b           <= i_second_vertex;
            r_ops_ok      <= n_a_ok && n_b_ok;
            r_active_mask <= n_mask;
        end
    end

    assign o_status_bus.action     = r_action;
    assign o_status_bus.ops_ok     = r_ops_ok;
    assign o_status_bus.pend_empty = (r_pending == '0);
    assign o_path_found            = r_found;
    assign o_status                = r_status;

`ifndef SYNTH
    // Every pending vertex has already been marked visited.
    a_pending_in_visited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pending & ~r_visited) == '0)
        else $error("pending vertex not marked visited");

    // A search step retires exactly one pending vertex.
    a_one_retire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.rd_en && i_cmd.rd_sel == RD_ROW_PEND && !i_cmd.q_init && r_pending != '0)
        |=> $countones(r_pending) == $countones($past(r_pending)) - 1)
        else $error("search step did not retire one vertex");
`endif

endmodule

// ===== src/grq_ctrl.sv =====
// Controller state machine sequencing edge updates and the component search.
`timescale 1ns / 1ps

module grq_ctrl
    import grq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    output logic       o_busy,
    output logic       o_done,
    output t_dp_cmd    o_cmd,
    input  t_dp_status i_status_bus
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_ADD_RD_A,
        S_ADD_WR_A,
        S_ADD_RD_B,
        S_ADD_WR_B,
        S_Q_ISSUE,
        S_Q_MERGE
    } t_state;

    t_state r_state;
    logic   r_done;

    // Commands decoded from the current state.
    always_comb begin
        o_cmd             = '0;
        o_cmd.rd_sel      = RD_ROW_PEND;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = i_start;
            end
            S_DECODE: begin
                o_cmd.clear_edges = (i_status_bus.action == ACT_CLEAR);
                o_cmd.q_init      = (i_status_bus.action == ACT_QUERY) && i_status_bus.ops_ok;
            end
            S_ADD_RD_A: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_ROW_A;
            end
            S_ADD_WR_A: begin
                o_cmd.wr_en = 1'b1;
            end
            S_ADD_RD_B: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_ROW_B;
            end
            S_ADD_WR_B: begin
                o_cmd.wr_en    = 1'b1;
                o_cmd.wr_row_b = 1'b1;
            end
            S_Q_ISSUE: begin
                o_cmd.rd_en = !i_status_bus.pend_empty;
            end
            S_Q_MERGE: begin
                o_cmd.merge = 1'b1;
            end
            default: begin
                o_cmd.load = 1'b0;
            end
        endcase
    end

    // State register and the registered result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    priority if (i_status_bus.action == ACT_ADD && i_status_bus.ops_ok) begin
                        r_state <= S_ADD_RD_A;
                    end else if (i_status_bus.action == ACT_QUERY && i_status_bus.ops_ok) begin
                        r_state <= S_Q_ISSUE;
                    end else if (i_status_bus.action == ACT_QUERY) begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_ADD_RD_A: r_state <= S_ADD_WR_A;
                S_ADD_WR_A: r_state <= S_ADD_RD_B;
                S_ADD_RD_B: r_state <= S_ADD_WR_B;
                S_ADD_WR_B: r_state <= S_IDLE;
                S_Q_ISSUE: begin
                    if (i_status_bus.pend_empty) begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_Q_MERGE;
                    end
                end
                S_Q_MERGE: r_state <= S_Q_ISSUE;
                default:   r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;

`ifndef SYNTH
    // A result is shown only once the block has returned to idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_state == S_IDLE)
        else $error("result strobe outside idle");

    // The result strobe never lasts more than one cycle.
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("result strobe held");

    // An accepted item always makes the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("accepted item did not start work");
`endif

endmodule

// ===== src/graph_reachability_query_top.sv =====
// Top level of the graph reachability query block: controller plus datapath.
`timescale 1ns / 1ps
// A query visits every vertex in the start component (at most 64) once;
// each visited vertex costs one adjacency row read and one merge of that row.
// Only queries raise the result strobe o_done, in the first idle cycle; the receiver cannot stall.
// Synchronous active-low reset clears all edges and sets vertex_count to 64.

module graph_reachability_query_top
    import grq_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [ACT_W-1:0] i_action,
    input  logic [VTX_W-1:0] i_first_vertex,
    input  logic [VTX_W-1:0] i_second_vertex,
    output logic             o_done,
    output logic             o_path_found,
    output logic             o_status,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [VTX_W-1:0] i_cfg_data
);

    t_dp_cmd    cmd;
    t_dp_status status_bus;

    // Configuration is taken only while the block is idle and no item is offered.
    assign o_cfg_ready = !busy && !start;

    grq_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .o_busy       (busy),
        .o_done       (o_done),
        .o_cmd        (cmd),
        .i_status_bus (status_bus)
    );

    grq_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status_bus    (status_bus),
        .i_action        (i_action),
        .i_first_vertex  (i_first_vertex),
        .i_second_vertex (i_second_vertex),
        .i_cfg_we        (i_cfg_valid && o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .o_path_found    (o_path_found),
        .o_status        (o_status)
    );

endmodule
